[hdl/key_handle_owner_table_assert.svh]
// Assertion macros used by the key handle owner table RTL.
`ifndef KEY_HANDLE_OWNER_TABLE_ASSERT_SVH
`define KEY_HANDLE_OWNER_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KHOT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define KHOT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/khot_pkg.sv]
// Package: table size, codes and the structs between the sequencer and the slot store.
package khot_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int HANDLE_W = 16;
   localparam int OWNER_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_PERMITTED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID_HANDLE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BACKEND_FAILED = 3'd4;

   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic                  used;
      logic [HANDLE_W-1:0]   handle;
      logic [OWNER_W-1:0]    owner;
   } slot_wr_type;

   typedef struct packed {
      logic                used;
      logic [HANDLE_W-1:0] handle;
      logic [OWNER_W-1:0]  owner;
   } slot_rd_type;

endpackage

[hdl/khot_slot_store.sv]
// Slot store: handle/owner memory with registered read, plus per-slot used flags.
module khot_slot_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [khot_pkg::SLOT_IDX_W-1:0] rd_addr,
   input  khot_pkg::slot_wr_type           wr,
   output khot_pkg::slot_rd_type           rd
);

   typedef struct packed {
      logic [khot_pkg::HANDLE_W-1:0] handle;
      logic [khot_pkg::OWNER_W-1:0]  owner;
   } entry_type;

   entry_type                        mem [khot_pkg::SLOT_COUNT];
   logic [khot_pkg::SLOT_COUNT-1:0]  used_ff;
   khot_pkg::slot_rd_type            rd_ff;

   // used flags double as valid bits: a slot that is not used is never read for data
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr.en) begin
         used_ff[wr.idx] <= wr.used;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= '{handle: wr.handle, owner: wr.owner};
      end
   end

   always_ff @(posedge clock) begin
      rd_ff.used   <= used_ff[rd_addr];
      rd_ff.handle <= mem[rd_addr].handle;
      rd_ff.owner  <= mem[rd_addr].owner;
   end

   assign rd = rd_ff;

endmodule

[hdl/key_handle_owner_table.sv]
// Key handle owner table: request sequencer walking the slot store, and result register.
//
// Requests enter on the req_ stream (func and backend_ok in tuser, handle and owner in
// tdata); one result word per request leaves on the rsp_ stream (status in tuser, slot
// in tdata). A request is taken only while the sequencer is idle.
// Each allocate, check or release request walks the slots from index 0, one slot per
// cycle, through the store's single read port, whose read is registered. The walk stops
// at the lowest free slot (allocate) or at the lowest used slot holding the handle
// (check, release), or at the last slot if none matches. The table update is written
// in the cycle the walk stops. Unused func code three answers invalid handle without
// touching the table.
// If rsp_tready is low the result waits in the output register; a finished walk waits
// in a holding register until the output register frees, and no new request is taken.
// Reset clears all used flags at once, so the table starts empty with no sweep; the
// output register and sequencer return to idle.
`include "key_handle_owner_table_assert.svh"

module key_handle_owner_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] handle_id, [47:16] owner_id
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] backend_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] slot, [7:4] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int IDX_W = khot_pkg::SLOT_IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(khot_pkg::SLOT_COUNT - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [khot_pkg::FUNC_W-1:0]          func_ff;
   logic [khot_pkg::HANDLE_W-1:0]        handle_ff;
   logic signed [khot_pkg::OWNER_W-1:0]  owner_ff;
   logic                                 ok_ff;

   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             p_valid_ff;
   logic [IDX_W-1:0] p_idx_ff;

   logic [khot_pkg::STATUS_W-1:0] hold_status_ff;
   logic [khot_pkg::SLOT_W-1:0]   hold_slot_ff;

   logic                          rsp_valid_ff;
   logic [khot_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [khot_pkg::SLOT_W-1:0]   rsp_slot_ff;

   khot_pkg::slot_wr_type wr;
   khot_pkg::slot_rd_type rd;

   logic                          req_take;
   logic                          out_free;
   logic                          hit;
   logic                          decide;
   logic [khot_pkg::STATUS_W-1:0] res_status;
   logic [khot_pkg::SLOT_W-1:0]   res_slot;

   khot_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (addr_ff),
      .wr      (wr),
      .rd      (rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign addr_in    = (addr_ff == LAST_IDX) ? '0 : addr_ff + IDX_W'(1);

   // walk decision on the word read back for slot p_idx_ff
   always_comb begin
      if (func_ff == khot_pkg::FUNC_ALLOC) begin
         hit = !rd.used;
      end else begin
         hit = rd.used && (rd.handle == handle_ff);
      end
      decide = (state_ff == S_WALK) && p_valid_ff && (hit || (p_idx_ff == LAST_IDX));

      res_status = khot_pkg::STATUS_INVALID_HANDLE;
      res_slot   = '0;
      wr         = '{en: 1'b0, idx: p_idx_ff, used: 1'b0, handle: '0, owner: '0};

      if (func_ff == khot_pkg::FUNC_ALLOC) begin
         if (!hit) begin
            res_status = khot_pkg::STATUS_NO_SPACE;
         end else if (!ok_ff) begin
            res_status = khot_pkg::STATUS_BACKEND_FAILED;
         end else begin
            res_status = khot_pkg::STATUS_OK;
            res_slot   = khot_pkg::SLOT_W'(p_idx_ff);
            wr.en      = decide;
            wr.used    = 1'b1;
            wr.handle  = handle_ff;
            wr.owner   = owner_ff;
         end
      end else if (hit) begin
         if (rd.owner != owner_ff) begin
            res_status = khot_pkg::STATUS_NOT_PERMITTED;
         end else if (func_ff == khot_pkg::FUNC_RELEASE && !ok_ff) begin
            res_status = khot_pkg::STATUS_BACKEND_FAILED;
         end else begin
            res_status = khot_pkg::STATUS_OK;
            res_slot   = khot_pkg::SLOT_W'(p_idx_ff);
            // release clears the slot's used flag and zeroes its handle and owner
            wr.en      = decide && (func_ff == khot_pkg::FUNC_RELEASE);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (req_tuser[1:0] inside {khot_pkg::FUNC_ALLOC, khot_pkg::FUNC_CHECK,
                                                  khot_pkg::FUNC_RELEASE}) ? S_WALK : S_HOLD;
            end
         end
         S_WALK: begin
            if (decide) begin
               state_in = out_free ? S_IDLE : S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (state_ff == S_WALK && !decide) begin
            p_valid_ff <= 1'b1;
         end else begin
            p_valid_ff <= 1'b0;
         end

         if ((state_ff == S_WALK && decide && out_free) || (state_ff == S_HOLD && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff        <= req_tuser[1:0];
         ok_ff          <= req_tuser[2];
         handle_ff      <= req_tdata[15:0];
         owner_ff       <= req_tdata[47:16];
         addr_ff        <= '0;
         hold_status_ff <= khot_pkg::STATUS_INVALID_HANDLE;
         hold_slot_ff   <= '0;
      end else if (state_ff == S_WALK) begin
         addr_ff  <= addr_in;
         p_idx_ff <= addr_ff;
      end

      if (state_ff == S_WALK && decide) begin
         hold_status_ff <= res_status;
         hold_slot_ff   <= res_slot;
      end

      if (state_ff == S_WALK && decide && out_free) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
      end else if (state_ff == S_HOLD && out_free) begin
         rsp_status_ff <= hold_status_ff;
         rsp_slot_ff   <= hold_slot_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff};

   `KHOT_ASSERT_NEXT(a_take_leaves_idle, clock, reset, req_take, state_ff != S_IDLE, "request taken but sequencer still idle")
   `KHOT_ASSERT_NOW(a_fail_slot_zero, clock, reset, rsp_tvalid && rsp_tuser != khot_pkg::STATUS_OK, rsp_tdata == 8'd0, "failed result carries a nonzero slot")
   `KHOT_ASSERT_NOW(a_write_on_decide, clock, reset, wr.en, state_ff == S_WALK && p_valid_ff, "table written outside a walk decision")

endmodule
